### rtl/core/sfmt_pkg.sv
// ----------------------------------------------------------------------------
// SFMT-19937 generator package
// Shared constants and types for the generator core and its submodules.
// ----------------------------------------------------------------------------
`default_nettype none

package sfmt_pkg;

    localparam int unsigned STATE_ENTRIES = 156;
    localparam int unsigned WORDS64       = 2 * STATE_ENTRIES;
    localparam int unsigned RECUR_POS     = 122;
    localparam int unsigned LANE_SHL      = 18;
    localparam int unsigned LANE_SHR      = 11;
    localparam int unsigned ADDR_W        = $clog2(STATE_ENTRIES);
    localparam int unsigned POS_W         = $clog2(WORDS64 + 1);

    localparam logic [63:0]  INIT_MULT  = 64'd6364136223846793005;
    localparam logic [31:0]  PARITY_TOP = 32'h13c9e684;
    localparam logic [127:0] LANE_MASK  =
        {32'hbffffff6, 32'hbffaffff, 32'hddfecb7f, 32'hdfffffef};

    typedef logic [1:0] t_op;
    localparam t_op OP_RAW    = 2'd0;
    localparam t_op OP_BOUND  = 2'd1;
    localparam t_op OP_FRAC   = 2'd2;
    localparam t_op OP_RESEED = 2'd3;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [127:0]      t_entry;

    typedef struct packed {
        logic   we;
        t_addr  waddr;
        t_entry wdata;
        t_addr  raddr;
    } t_mem_req;

    function automatic t_entry recur(input t_entry a, input t_entry b,
                                     input t_entry c, input t_entry d);
        t_entry x;
        t_entry y;
        t_entry r;
        x = a << 8;
        y = c >> 8;
        for (int k = 0; k < 4; k++) begin
            r[32*k +: 32] = a[32*k +: 32] ^ x[32*k +: 32]
                          ^ ((b[32*k +: 32] >> LANE_SHR) & LANE_MASK[32*k +: 32])
                          ^ y[32*k +: 32] ^ (d[32*k +: 32] << LANE_SHL);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/sfmt_state_ram.sv
// ----------------------------------------------------------------------------
// SFMT state memory
// 156 x 128-bit synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sfmt_state_ram (
    input  wire logic             i_clk,
    input  wire sfmt_pkg::t_mem_req i_req,
    output logic [127:0]          o_rdata
);
    import sfmt_pkg::*;

    t_entry r_mem [STATE_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end

endmodule

`default_nettype wire

### rtl/core/sfmt_mul64.sv
// ----------------------------------------------------------------------------
// SFMT seed multiplier
// 64x64 low-half product by the init constant, three 32x32 partials over stages.
// ----------------------------------------------------------------------------
`default_nettype none

module sfmt_mul64 (
    input  wire logic        i_clk,
    input  wire logic [63:0] i_a,
    output logic [63:0]      o_p
);
    import sfmt_pkg::*;

    logic [63:0] r_ll;
    logic [31:0] r_lh;
    logic [31:0] r_hl;

    always_ff @(posedge i_clk) begin
        r_ll <= 64'(i_a[31:0]) * 64'(INIT_MULT[31:0]);
        r_lh <= 32'(i_a[31:0] * INIT_MULT[63:32]);
        r_hl <= 32'(i_a[63:32] * INIT_MULT[31:0]);
        o_p  <= r_ll + {r_lh + r_hl, 32'd0};
    end

endmodule

`default_nettype wire

### rtl/core/sfmt19937_random_generator_core.sv
// ----------------------------------------------------------------------------
// SFMT-19937 random generator core
// Raw words, bounded integers and 0.23 fractions from a 156-entry state RAM.
// A drawn word passes DRAW, DWAIT and DUSE to the result register; a rejected
// bounded draw repeats them. A new request waits until the result is taken.
// Regeneration when 312 words are used up: GP0-GP2 preload, GRD to GWR per entry.
// Reseed: SWR and SMUL to SM3 per 64-bit word, then a parity fix in PRD to PWR.
// Reset clears control and the seed register; the state RAM is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sfmt19937_random_generator_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_operation,
    input  wire logic [63:0] i_bound,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [63:0]      o_value
);
    import sfmt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DRAW, S_DWAIT, S_DUSE, S_GP0, S_GP1, S_GP2, S_GRD, S_GW1, S_GW2,
        S_GWR, S_SMUL, S_SM1, S_SM2, S_SM3, S_SWR, S_PRD, S_PWAIT, S_PWR
    } t_state;

    t_state       r_state;
    logic [POS_W-1:0] r_pos;
    logic [63:0]  r_seed;
    t_op          r_op;
    logic [63:0]  r_bound;
    logic [63:0]  r_mask;
    logic         r_ovalid;
    logic [63:0]  r_value;
    t_addr        r_gi;
    t_entry       r_ga;
    t_entry       r_gb;
    t_entry       r_r1;
    t_entry       r_r2;
    logic [POS_W-1:0] r_si;
    logic [63:0]  r_prev;
    logic [63:0]  r_lo;

    t_mem_req     mem_req;
    t_entry       rdata;
    logic [63:0]  mul_p;
    logic [63:0]  word;
    logic [63:0]  m;
    logic [31:0]  par;
    t_addr        gb_idx;
    t_entry       gnew;

    sfmt_state_ram u_ram (.i_clk(i_clk), .i_req(mem_req), .o_rdata(rdata));
    sfmt_mul64 u_mul (.i_clk(i_clk), .i_a(r_prev ^ (r_prev >> 62)), .o_p(mul_p));

    assign o_cfg_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_stall     = (r_state != S_IDLE) || r_ovalid;
    assign o_valid     = r_ovalid;
    assign o_value     = r_value;

    assign word = r_pos[0] ? rdata[127:64] : rdata[63:0];
    assign gb_idx = (r_gi < ADDR_W'(STATE_ENTRIES - RECUR_POS))
                  ? ADDR_W'(r_gi + ADDR_W'(RECUR_POS))
                  : ADDR_W'(r_gi - ADDR_W'(STATE_ENTRIES - RECUR_POS));
    assign gnew = recur(r_ga, r_gb, r_r1, r_r2);
    assign par  = (rdata[31:0] & 32'd1) ^ (rdata[127:96] & PARITY_TOP);

    always_comb begin
        m = i_bound;
        m = m | (m >> 1);
        m = m | (m >> 2);
        m = m | (m >> 4);
        m = m | (m >> 8);
        m = m | (m >> 16);
        m = m | (m >> 32);
    end

    always_comb begin
        mem_req = '0;
        mem_req.raddr = ADDR_W'(r_pos >> 1);
        case (r_state)
            S_GP0:  mem_req.raddr = ADDR_W'(STATE_ENTRIES - 2);
            S_GP1:  mem_req.raddr = ADDR_W'(STATE_ENTRIES - 1);
            S_GRD:  mem_req.raddr = r_gi;
            S_GW1:  mem_req.raddr = gb_idx;
            S_GWR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_gi;
                mem_req.wdata = gnew;
            end
            S_SWR: begin
                mem_req.we    = r_si[0];
                mem_req.waddr = ADDR_W'(r_si >> 1);
                mem_req.wdata = {r_prev, r_lo};
            end
            S_PRD:   mem_req.raddr = '0;
            S_PWAIT: mem_req.raddr = '0;
            S_PWR: begin
                mem_req.raddr = '0;
                mem_req.we    = ~^par;
                mem_req.waddr = '0;
                mem_req.wdata = rdata ^ 128'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pos    <= POS_W'(WORDS64);
            r_seed   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_seed <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_op    <= i_operation;
                        r_bound <= i_bound;
                        r_mask  <= m;
                        if (i_operation == OP_RESEED) begin
                            r_prev  <= r_seed;
                            r_si    <= '0;
                            r_state <= S_SWR;
                        end else if (i_operation == OP_BOUND && i_bound == '0) begin
                            r_value  <= '0;
                            r_ovalid <= 1'b1;
                        end else begin
                            r_state <= S_DRAW;
                        end
                    end
                end
                S_DRAW: begin
                    if (r_pos >= POS_W'(WORDS64)) begin
                        r_gi    <= '0;
                        r_state <= S_GP0;
                    end else begin
                        r_state <= S_DWAIT;
                    end
                end
                S_DWAIT: r_state <= S_DUSE;
                S_DUSE: begin
                    r_pos <= r_pos + 1'b1;
                    if (r_op == OP_BOUND && (word & r_mask) >= r_bound) begin
                        r_state <= S_DRAW;
                    end else begin
                        case (r_op)
                            OP_RAW:   r_value <= word;
                            OP_BOUND: r_value <= word & r_mask;
                            default:  r_value <= {41'd0, word[31:9]};
                        endcase
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_GP0: r_state <= S_GP1;
                S_GP1: begin
                    r_r1    <= rdata;
                    r_state <= S_GP2;
                end
                S_GP2: begin
                    r_r2    <= rdata;
                    r_state <= S_GRD;
                end
                S_GRD: r_state <= S_GW1;
                S_GW1: begin
                    r_ga    <= rdata;
                    r_state <= S_GW2;
                end
                S_GW2: begin
                    r_gb    <= rdata;
                    r_state <= S_GWR;
                end
                S_GWR: begin
                    r_r1 <= r_r2;
                    r_r2 <= gnew;
                    if (r_gi == ADDR_W'(STATE_ENTRIES - 1)) begin
                        r_pos   <= '0;
                        r_state <= S_DWAIT;
                    end else begin
                        r_gi    <= r_gi + 1'b1;
                        r_state <= S_GRD;
                    end
                end
                S_SWR: begin
                    r_lo <= r_prev;
                    if (r_si == POS_W'(WORDS64 - 1)) begin
                        r_state <= S_PRD;
                    end else begin
                        r_state <= S_SMUL;
                    end
                end
                S_SMUL: r_state <= S_SM1;
                S_SM1:  r_state <= S_SM2;
                S_SM2:  r_state <= S_SM3;
                S_SM3: begin
                    r_prev  <= mul_p + 64'(r_si + 1'b1);
                    r_si    <= r_si + 1'b1;
                    r_state <= S_SWR;
                end
                S_PRD:   r_state <= S_PWAIT;
                S_PWAIT: r_state <= S_PWR;
                S_PWR: begin
                    r_pos    <= POS_W'(WORDS64);
                    r_value  <= '0;
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_value))
        else $error("result changed while held");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> o_stall)
        else $error("transfer accepted while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(WORDS64))
        else $error("read position out of range");

endmodule

`default_nettype wire
